>>> design/upq_pkg.sv
// Shared types and constants for the unsorted priority queue.
package upq_pkg;

  localparam int unsigned ReqW        = 3;
  localparam int unsigned TagW        = 32;
  localparam int unsigned PriW        = 32;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CountW      = 5;
  localparam int unsigned EntryW      = TagW + PriW;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [ReqW-1:0] {
    REQ_ENQUEUE  = 3'd0,
    REQ_DEQUEUE  = 3'd1,
    REQ_PEEK     = 3'd2,
    REQ_CHANGE   = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NOT_URGENT = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_FINISH
  } fsm_e;

endpackage

>>> design/unsorted_priority_queue.sv
// Unsorted min-priority queue: entries kept in arrival order in one RAM, served by a scan.
//
// Entries live in insertion order in a single RAM with one read and one write port;
// one comparator walks them one per cycle. Enqueue, clear and unknown request kinds
// go straight to the finish state; peek scans all held entries; change priority
// scans up to the first matching tag (all entries when absent); dequeue scans all
// held entries, then moves each entry behind the removed one down a slot. Requests
// on an empty queue also go straight to the finish state. The RAM's single read
// port sets the pace of the scan. One request is in work at a time; the result sits
// in an output register, so a new request is taken while the previous result waits
// to be read.
module unsorted_priority_queue
  import upq_pkg::*;
#(
  parameter int unsigned DEPTH = upq_pkg::DefaultDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [upq_pkg::ReqW-1:0]          req_type_i,
  input  logic [upq_pkg::TagW-1:0]          value_tag_i,
  input  logic signed [upq_pkg::PriW-1:0]   priority_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [upq_pkg::StatusW-1:0]       status_o,
  output logic [upq_pkg::TagW-1:0]          out_value_o,
  output logic signed [upq_pkg::PriW-1:0]   out_priority_o,
  output logic [upq_pkg::CountW-1:0]        entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fsm_e               state_q, state_d;
  req_e               req_q, req_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic [PriW-1:0]    pri_q, pri_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      bidx_q, bidx_d;
  logic [TagW-1:0]    btag_q, btag_d;
  logic [PriW-1:0]    bpri_q, bpri_d;
  status_e            res_q, res_d;

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [TagW-1:0]    out_tag_q, out_tag_d;
  logic [PriW-1:0]    out_pri_q, out_pri_d;
  logic [CountW-1:0]  out_cnt_q, out_cnt_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EntryW-1:0]  ram_wdata, ram_rdata;
  logic [TagW-1:0]    rd_tag;
  logic [PriW-1:0]    rd_pri;
  logic               take, more, bmore, accept;

  upq_ram #(
    .Width(EntryW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_tag = ram_rdata[EntryW-1:PriW];
  assign rd_pri = ram_rdata[PriW-1:0];

  assign in_ready_o = (state_q == FSM_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Shared comparator: candidate beats the best so far, or is the first entry.
  assign take  = (idx_q == '0) || ($signed(rd_pri) < $signed(bpri_q));
  assign more  = (CW'(idx_q) + CW'(1)) < cnt_q;
  assign bmore = (CW'(take ? idx_q : bidx_q) + CW'(1)) < cnt_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    tag_d       = tag_q;
    pri_d       = pri_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    bidx_d      = bidx_q;
    btag_d      = btag_q;
    bpri_d      = bpri_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {tag_q, pri_q};
    ram_raddr   = idx_q;
    out_valid_d = out_valid_q;
    out_status_d = out_status_q;
    out_tag_d   = out_tag_q;
    out_pri_d   = out_pri_q;
    out_cnt_d   = out_cnt_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          req_d   = req_e'(req_type_i);
          tag_d   = value_tag_i;
          pri_d   = priority_req_i;
          idx_d   = '0;
          res_d   = ST_OK;
          ram_raddr = '0;
          state_d = FSM_FINISH;
          unique case (req_type_i)
            REQ_ENQUEUE: begin
              if (cnt_q >= CW'(DEPTH)) begin
                res_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = {value_tag_i, priority_req_i};
                cnt_d     = cnt_q + CW'(1);
              end
            end
            REQ_DEQUEUE, REQ_PEEK: begin
              if (cnt_q == '0) begin
                res_d = ST_EMPTY;
              end else begin
                state_d = FSM_SCAN;
              end
            end
            REQ_CHANGE: begin
              if (cnt_q == '0) begin
                res_d = ST_NOT_FOUND;
              end else begin
                state_d = FSM_SCAN;
              end
            end
            REQ_CLEAR: begin
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end

      FSM_SCAN: begin
        if (req_q == REQ_CHANGE) begin
          if (rd_tag == tag_q) begin
            state_d = FSM_FINISH;
            if ($signed(rd_pri) <= $signed(pri_q)) begin
              res_d = ST_NOT_URGENT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = idx_q;
              ram_wdata = {tag_q, pri_q};
            end
          end else if (more) begin
            idx_d     = idx_q + AW'(1);
            ram_raddr = idx_q + AW'(1);
          end else begin
            res_d   = ST_NOT_FOUND;
            state_d = FSM_FINISH;
          end
        end else begin
          if (take) begin
            bidx_d = idx_q;
            btag_d = rd_tag;
            bpri_d = rd_pri;
          end
          if (more) begin
            idx_d     = idx_q + AW'(1);
            ram_raddr = idx_q + AW'(1);
          end else if (req_q == REQ_DEQUEUE && bmore) begin
            // Close the gap: move each later entry down one slot.
            idx_d     = (take ? idx_q : bidx_q) + AW'(1);
            ram_raddr = (take ? idx_q : bidx_q) + AW'(1);
            state_d   = FSM_SHIFT;
          end else begin
            if (req_q == REQ_DEQUEUE) begin
              cnt_d = cnt_q - CW'(1);
            end
            state_d = FSM_FINISH;
          end
        end
      end

      FSM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        ram_wdata = ram_rdata;
        if (more) begin
          idx_d     = idx_q + AW'(1);
          ram_raddr = idx_q + AW'(1);
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = FSM_FINISH;
        end
      end

      FSM_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_cnt_d    = CountW'(cnt_q);
          if (res_q == ST_OK && (req_q == REQ_DEQUEUE || req_q == REQ_PEEK)) begin
            out_tag_d = btag_q;
            out_pri_d = bpri_q;
          end else begin
            out_tag_d = '0;
            out_pri_d = '0;
          end
          state_d = FSM_IDLE;
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    tag_q        <= tag_d;
    pri_q        <= pri_d;
    idx_q        <= idx_d;
    bidx_q       <= bidx_d;
    btag_q       <= btag_d;
    bpri_q       <= bpri_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
    out_pri_q    <= out_pri_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_value_o    = out_tag_q;
  assign out_priority_o = out_pri_q;
  assign entry_count_o  = out_cnt_q;

endmodule

>>> design/upq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module upq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
